[hw/rtl/gnbm_pkg.sv]
package gnbm_pkg;

  localparam int LOG_STEPS    = 24;
  localparam int SQRT_BITS    = 19;
  localparam int TAYLOR_STEPS = 6;

  localparam int RADIUS_LAT = 1 + LOG_STEPS + 2 + SQRT_BITS;
  localparam int COS_LAT    = 2 + 3 * TAYLOR_STEPS;
  localparam int COS_DELAY  = RADIUS_LAT - COS_LAT;

  localparam logic [32:0] TWO_LN2_Q32 = 33'h162E42FF0;
  localparam logic [30:0] TWO_PI_Q28  = 31'h6487ED51;
  localparam logic [30:0] Q30_ONE     = 31'h40000000;

  localparam logic [7:0] TAYLOR_DIV [TAYLOR_STEPS] = '{
    8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
  };

  localparam logic [31:0] TAYLOR_RECIP [TAYLOR_STEPS] = '{
    32'((64'd1 << 32) / 64'd132),
    32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd2)
  };

  localparam logic [15:0] SIGMA_RESET     = 16'd4096;
  localparam logic        REG_NOISE_SIGMA = 1'b0;
  localparam logic [20:0] SAMPLE_POS_MAX  = 21'd1048575;
  localparam logic [20:0] SAMPLE_NEG_MAX  = 21'd1048576;

  typedef logic [SQRT_BITS-1:0] radius_t;

  typedef struct packed {
    logic valid;
    logic last;
  } rad_ctl_t;

endpackage

[hw/rtl/gnbm_uniform_if.sv]
interface gnbm_uniform_if;
  logic        valid;
  logic        ready;
  logic [15:0] uniform_first;
  logic [15:0] uniform_second;
  logic        batch_end;

  modport source (output valid, uniform_first, uniform_second, batch_end, input ready);
  modport sink (input valid, uniform_first, uniform_second, batch_end, output ready);
endinterface

[hw/rtl/gnbm_noise_if.sv]
interface gnbm_noise_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] noise_sample;
  logic               batch_end_out;

  modport source (output valid, noise_sample, batch_end_out, input ready);
  modport sink (input valid, noise_sample, batch_end_out, output ready);
endinterface

[hw/rtl/gnbm_radius.sv]
module gnbm_radius (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  gnbm_pkg::rad_ctl_t ctl_in,
  input  logic [15:0]        uniform_first,
  output gnbm_pkg::rad_ctl_t ctl_out,
  output gnbm_pkg::radius_t  radius
);

  gnbm_pkg::rad_ctl_t ctl [gnbm_pkg::RADIUS_LAT];

  logic [3:0]  msb;
  logic [30:0] mant_norm;

  logic [30:0]                    mant [gnbm_pkg::LOG_STEPS+1];
  logic [gnbm_pkg::LOG_STEPS-1:0] frac [gnbm_pkg::LOG_STEPS+1];
  logic [3:0]                     expo [gnbm_pkg::LOG_STEPS+1];
  logic                           zero [gnbm_pkg::LOG_STEPS+1];

  logic [28:0] log_q24;
  logic [45:0] prod_lo;
  logic [44:0] prod_hi;
  logic [62:0] tsum;

  logic [37:0]       rem  [gnbm_pkg::SQRT_BITS+1];
  gnbm_pkg::radius_t root [gnbm_pkg::SQRT_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gnbm_pkg::RADIUS_LAT; i++) ctl[i] <= '0;
    end else if (en) begin
      ctl[0] <= ctl_in;
      for (int i = 1; i < gnbm_pkg::RADIUS_LAT; i++) ctl[i] <= ctl[i-1];
    end
  end

  assign ctl_out = ctl[gnbm_pkg::RADIUS_LAT-1];

  // normalize to a Q30 mantissa in [1,2)
  always_comb begin
    msb = '0;
    for (int i = 0; i < 16; i++) begin
      if (uniform_first[i]) msb = 4'(i);
    end
  end

  assign mant_norm = {15'd0, uniform_first} << (5'd30 - 5'(msb));

  always_ff @(posedge clk) begin
    if (en) begin
      mant[0] <= mant_norm;
      frac[0] <= '0;
      expo[0] <= msb;
      zero[0] <= (uniform_first == 16'd0);
    end
  end

  for (genvar g = 0; g < gnbm_pkg::LOG_STEPS; g++) begin : g_log
    logic [61:0] sq;
    logic [31:0] sh;

    assign sq = {31'd0, mant[g]} * {31'd0, mant[g]};
    assign sh = sq[61:30];

    always_ff @(posedge clk) begin
      if (en) begin
        mant[g+1] <= sh[31] ? sh[31:1] : sh[30:0];
        frac[g+1] <= {frac[g][gnbm_pkg::LOG_STEPS-2:0], sh[31]};
        expo[g+1] <= expo[g];
        zero[g+1] <= zero[g];
      end
    end
  end

  assign log_q24 = zero[gnbm_pkg::LOG_STEPS] ? 29'd0 :
    ({5'd16 - 5'(expo[gnbm_pkg::LOG_STEPS]), 24'd0} -
     {5'd0, frac[gnbm_pkg::LOG_STEPS]});

  // split 2 ln 2 product over two stages
  always_ff @(posedge clk) begin
    if (en) begin
      prod_lo <= 46'(log_q24) * 46'(gnbm_pkg::TWO_LN2_Q32[16:0]);
      prod_hi <= 45'(log_q24) * 45'(gnbm_pkg::TWO_LN2_Q32[32:17]);
    end
  end

  assign tsum = {1'b0, prod_hi, 17'd0} + 63'(prod_lo);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= tsum[61:24];
      root[0] <= '0;
    end
  end

  // one root bit per stage
  for (genvar s = 0; s < gnbm_pkg::SQRT_BITS; s++) begin : g_sqrt
    localparam int B = gnbm_pkg::SQRT_BITS - 1 - s;
    logic [39:0] trial;
    logic        fits;

    assign trial = (40'(root[s]) << (B + 1)) + (40'd1 << (2 * B));
    assign fits  = ({2'b00, rem[s]} >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= fits ? (rem[s] - trial[37:0]) : rem[s];
        root[s+1] <= fits ? (root[s] | (gnbm_pkg::radius_t'(1) << B)) : root[s];
      end
    end
  end

  assign radius = root[gnbm_pkg::SQRT_BITS];

`ifndef NO_ASSERTIONS
  a_mant_norm: assert property (@(posedge clk) disable iff (rst)
    ctl[gnbm_pkg::LOG_STEPS].valid |->
      (zero[gnbm_pkg::LOG_STEPS] || mant[gnbm_pkg::LOG_STEPS][30]))
    else $error("log mantissa left [1,2)");

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    ctl[gnbm_pkg::LOG_STEPS+2].valid |-> !rem[0][37])
    else $error("radius argument out of range");

  a_sqrt_floor: assert property (@(posedge clk) disable iff (rst)
    ctl[gnbm_pkg::RADIUS_LAT-1].valid |->
      ({1'b0, rem[gnbm_pkg::SQRT_BITS]} <= {19'd0, root[gnbm_pkg::SQRT_BITS], 1'b0}))
    else $error("square root remainder too large");
`endif

endmodule

[hw/rtl/gaussian_noise_box_muller_core.sv]
// Throughput: one transaction per cycle; the pipeline holds while the output stalls.
// The depth is set by the 24-step log2 squaring chain and the 19-step square root.
// Reset (rst, synchronous) empties the pipeline and sets noise_sigma to 1.0.
module gaussian_noise_box_muller_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  gnbm_uniform_if.sink      uniform,
  gnbm_noise_if.source      noise
);

  localparam int TS = gnbm_pkg::TAYLOR_STEPS;

  logic [15:0] noise_sigma;
  logic        en;

  gnbm_pkg::rad_ctl_t ctl_in, ctl_r;
  gnbm_pkg::radius_t  radius;

  logic [1:0]  quad;
  logic [14:0] angle;
  logic [45:0] xsum;
  logic [30:0] x_q;
  logic        neg0;
  logic [61:0] xsq;

  logic [31:0] z_t   [TS+1];
  logic [30:0] c_t   [TS+1];
  logic        neg_t [TS+1];

  logic [30:0] c_d   [gnbm_pkg::COS_DELAY];
  logic        neg_d [gnbm_pkg::COS_DELAY];

  logic [50:0] rc_sum;
  logic [19:0] rc;
  logic        neg_p1;
  logic [36:0] mag_sum;
  logic [20:0] mag;
  logic        neg_p2;
  logic [20:0] sample_next;

  logic v1, v2, vo;
  logic l1, l2, lo;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_sigma <= gnbm_pkg::SIGMA_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == gnbm_pkg::REG_NOISE_SIGMA)) begin
      noise_sigma <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == gnbm_pkg::REG_NOISE_SIGMA) ? {16'd0, noise_sigma} : 32'd0;

  assign en            = !vo || noise.ready;
  assign uniform.ready = en;

  assign ctl_in = '{valid: uniform.valid, last: uniform.batch_end};

  gnbm_radius u_radius (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .ctl_in        (ctl_in),
    .uniform_first (uniform.uniform_first),
    .ctl_out       (ctl_r),
    .radius        (radius)
  );

  // phase to quarter-wave angle
  assign quad  = uniform.uniform_second[15:14];
  assign angle = quad[0] ? (15'd16384 - {1'b0, uniform.uniform_second[13:0]})
                         : {1'b0, uniform.uniform_second[13:0]};
  assign xsum  = 46'(angle) * 46'(gnbm_pkg::TWO_PI_Q28) + 46'd8192;
  assign xsq   = {31'd0, x_q} * {31'd0, x_q};

  always_ff @(posedge clk) begin
    if (en) begin
      x_q      <= xsum[44:14];
      neg0     <= (quad == 2'd1) || (quad == 2'd2);
      z_t[0]   <= xsq[61:30];
      c_t[0]   <= gnbm_pkg::Q30_ONE;
      neg_t[0] <= neg0;
    end
  end

  // Horner steps: multiply, reciprocal divide, correct
  for (genvar j = 0; j < TS; j++) begin : g_taylor
    logic [62:0] zc;
    logic [31:0] y1, y2;
    logic [31:0] z1, z2;
    logic        n1, n2;
    logic [63:0] yq;
    logic [31:0] q0;
    logic [31:0] rmd;
    logic [31:0] d;

    assign zc  = {31'd0, z_t[j]} * {32'd0, c_t[j]};
    assign yq  = {32'd0, y1} * {32'd0, gnbm_pkg::TAYLOR_RECIP[j]};
    assign rmd = y2 - 32'(q0 * 32'(gnbm_pkg::TAYLOR_DIV[j]));
    assign d   = (rmd >= 32'(gnbm_pkg::TAYLOR_DIV[j])) ? (q0 + 32'd1) : q0;

    always_ff @(posedge clk) begin
      if (en) begin
        y1         <= zc[61:30];
        z1         <= z_t[j];
        n1         <= neg_t[j];
        q0         <= yq[63:32];
        y2         <= y1;
        z2         <= z1;
        n2         <= n1;
        c_t[j+1]   <= (d >= {1'b0, gnbm_pkg::Q30_ONE}) ? 31'd0 :
                      31'({1'b0, gnbm_pkg::Q30_ONE} - d);
        z_t[j+1]   <= z2;
        neg_t[j+1] <= n2;
      end
    end
  end

  // align cosine with the radius
  always_ff @(posedge clk) begin
    if (en) begin
      c_d[0]   <= c_t[TS];
      neg_d[0] <= neg_t[TS];
      for (int i = 1; i < gnbm_pkg::COS_DELAY; i++) begin
        c_d[i]   <= c_d[i-1];
        neg_d[i] <= neg_d[i-1];
      end
    end
  end

  assign rc_sum  = {1'b0, 50'({31'd0, radius} * {19'd0, c_d[gnbm_pkg::COS_DELAY-1]})}
                   + 51'(1 << 29);
  assign mag_sum = 37'({21'd0, noise_sigma} * {17'd0, rc}) + 37'd32768;

  always_comb begin
    if (neg_p2) begin
      sample_next = (mag > gnbm_pkg::SAMPLE_NEG_MAX) ? (21'd0 - gnbm_pkg::SAMPLE_NEG_MAX)
                                                     : (21'd0 - mag);
    end else begin
      sample_next = (mag > gnbm_pkg::SAMPLE_POS_MAX) ? gnbm_pkg::SAMPLE_POS_MAX : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc                 <= rc_sum[49:30];
      neg_p1             <= neg_d[gnbm_pkg::COS_DELAY-1];
      mag                <= mag_sum[36:16];
      neg_p2             <= neg_p1;
      noise.noise_sample <= sample_next;
      l1                 <= ctl_r.last;
      l2                 <= l1;
      lo                 <= l2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else if (en) begin
      v1 <= ctl_r.valid;
      v2 <= v1;
      vo <= v2;
    end
  end

  assign noise.valid         = vo;
  assign noise.batch_end_out = lo;

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !noise.valid)
    else $error("output valid after reset");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    ctl_r.valid |-> (c_d[gnbm_pkg::COS_DELAY-1] <= gnbm_pkg::Q30_ONE))
    else $error("cosine above one");

  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    ctl_r.valid && en && (radius == '0) |=> v1 && (rc == 20'd0))
    else $error("zero radius gave nonzero product");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    v2 && en && !neg_p2 |=> vo && !noise.noise_sample[20])
    else $error("positive sample has sign bit set");
`endif

endmodule

[verif/gaussian_noise_box_muller_core_tb.sv]
`timescale 1ns / 100ps

module gaussian_noise_box_muller_core_tb;

  localparam int LATENCY    = 49;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [2:0] ADDR_NOISE_SIGMA = 3'd0;
  localparam logic [2:0] ADDR_UNUSED      = 3'd4;

  typedef struct packed {
    logic [15:0] uniform_first;
    logic [15:0] uniform_second;
    logic        batch_end;
  } uniform_item_t;

  typedef struct packed {
    logic signed [20:0] noise_sample;
    logic               batch_end_out;
  } noise_item_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  gnbm_uniform_if uniform ();
  gnbm_noise_if noise ();

  gaussian_noise_box_muller_core dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .uniform(uniform.sink), .noise(noise.source)
  );

  uniform_item_t pending_q[$];
  noise_item_t   sample_q[$];
  logic [15:0]   sigma_shadow;
  int            errors;
  int            samples_seen;
  int            idle_cycles;
  bit            timed_out;
  bit            send_idle_off;
  bit            recv_idle_off;
  bit            send_pause;
  int            recv_holdoff;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] neg_log2_q24(logic [63:0] v);
    int e;
    logic [63:0] m, frac;
    e = 0;
    frac = 0;
    if (v >= 65536) return 0;
    while ((v >> (e + 1)) != 0) e++;
    m = v << (30 - e);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (64'(16 - e) << 24) - frac;
  endfunction

  function automatic logic [63:0] cos_q30(logic [63:0] a);
    logic [63:0] x, z, c, d;
    logic [63:0] divs [6];
    divs = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};
    x = (a * 64'h6487ED51 + (64'd1 << 13)) >> 14;
    z = (x * x) >> 30;
    c = 64'd1 << 30;
    for (int i = 0; i < 6; i++) begin
      d = ((z * c) >> 30) / divs[i];
      c = (d >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - d;
    end
    return c;
  endfunction

  function automatic noise_item_t gaussian_sample(uniform_item_t it, logic [15:0] sigma);
    noise_item_t o;
    logic [63:0] v1, t, r, c, rc, mag;
    logic [1:0] quad;
    logic [13:0] p;
    bit neg;
    v1 = it.uniform_first;
    if (v1 == 0) v1 = 65536;
    t = (neg_log2_q24(v1) * 64'h162E42FF0) >> 24;
    r = isqrt64(t);
    quad = it.uniform_second[15:14];
    p = it.uniform_second[13:0];
    c = cos_q30(quad[0] ? 64'd16384 - p : 64'(p));
    neg = (quad == 2'd1 || quad == 2'd2);
    rc = (r * c + (64'd1 << 29)) >> 30;
    mag = (64'(sigma) * rc + (64'd1 << 15)) >> 16;
    if (neg) begin
      if (mag > 64'd1048576) mag = 64'd1048576;
      o.noise_sample = 21'(64'd0 - mag);
    end else begin
      if (mag > 64'd1048575) mag = 64'd1048575;
      o.noise_sample = 21'(mag);
    end
    o.batch_end_out = it.batch_end;
    return o;
  endfunction

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_NOISE_SIGMA) sigma_shadow = data[15:0];
  endtask

  task automatic drain();
    while ((pending_q.size() != 0 || uniform.valid || sample_q.size() != 0) && !timed_out)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic push_item(logic [15:0] a, logic [15:0] b, logic e);
    uniform_item_t it;
    it.uniform_first = a;
    it.uniform_second = b;
    it.batch_end = e;
    pending_q.push_back(it);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: push_item(16'($urandom_range(0, 15)), 16'($urandom), 1'($urandom));
        1: push_item(16'($urandom), 16'($urandom_range(0, 3)) << 14 | 16'($urandom_range(0, 3)),
                     1'($urandom));
        default: push_item(16'($urandom), 16'($urandom), 1'($urandom));
      endcase
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      uniform.valid <= 1'b0;
    end else if (!uniform.valid || uniform.ready) begin
      if (pending_q.size() != 0 && !send_pause &&
          (send_idle_off || $urandom_range(0, 99) >= 37)) begin
        uniform_item_t it;
        it = pending_q.pop_front();
        uniform.valid <= 1'b1;
        uniform.uniform_first <= it.uniform_first;
        uniform.uniform_second <= it.uniform_second;
        uniform.batch_end <= it.batch_end;
        sample_q.push_back(gaussian_sample(it, sigma_shadow));
      end else begin
        uniform.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      noise.ready <= 1'b0;
    end else begin
      if (noise.valid && noise.ready) begin
        if (sample_q.size() == 0) begin
          $display("%0t: unexpected sample %0d last %0b", $time, noise.noise_sample,
                   noise.batch_end_out);
          errors++;
        end else begin
          noise_item_t exp_s;
          exp_s = sample_q.pop_front();
          if (exp_s.noise_sample !== noise.noise_sample)
            begin
              $display("%0t: noise_sample expected %0d actual %0d", $time,
                       exp_s.noise_sample, noise.noise_sample);
              errors++;
            end
          if (exp_s.batch_end_out !== noise.batch_end_out) begin
            $display("%0t: batch_end_out expected %0b actual %0b", $time,
                     exp_s.batch_end_out, noise.batch_end_out);
            errors++;
          end
        end
        samples_seen++;
      end
      if (recv_holdoff > 0) begin
        recv_holdoff <= recv_holdoff - 1;
        noise.ready <= 1'b0;
      end else begin
        noise.ready <= recv_idle_off || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (uniform.valid && uniform.ready) || (noise.valid && noise.ready) ||
        (sample_q.size() == 0 && !uniform.valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        timed_out = 1'b1;
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  logic [15:0] sigmas [5];

  initial begin
    errors = 0; samples_seen = 0; idle_cycles = 0; timed_out = 0;
    send_idle_off = 0; recv_idle_off = 0; recv_holdoff = 0; send_pause = 0;
    sigma_shadow = gnbm_pkg::SIGMA_RESET;
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    uniform.valid = 0; uniform.uniform_first = 0; uniform.uniform_second = 0;
    uniform.batch_end = 0;
    noise.ready = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset sigma
    push_item(16'd0, 16'd0, 1'b0);
    push_item(16'd0, 16'hFFFF, 1'b1);
    push_item(16'd1, 16'd0, 1'b0);
    push_item(16'd1, 16'h4000, 1'b1);
    push_item(16'd1, 16'h8000, 1'b0);
    push_item(16'd1, 16'hC000, 1'b1);
    push_item(16'd1, 16'h3FFF, 1'b0);
    push_item(16'd1, 16'h7FFF, 1'b1);
    push_item(16'd1, 16'hBFFF, 1'b0);
    push_item(16'd1, 16'hFFFF, 1'b1);
    push_item(16'hFFFF, 16'h0000, 1'b0);
    push_item(16'hFFFF, 16'h8000, 1'b1);
    push_item(16'h8000, 16'h2000, 1'b0);
    push_item(16'h5555, 16'hAAAA, 1'b1);
    push_item(16'hAAAA, 16'h5555, 1'b0);
    push_item(16'hFFFF, 16'h4000, 1'b1);
    drain();

    // saturation and negative zero at the sigma extremes
    write_reg(ADDR_NOISE_SIGMA, 32'hFFFF_FFFF);
    write_reg(ADDR_UNUSED, 32'h0000_1234);
    push_item(16'd1, 16'd0, 1'b0);
    push_item(16'd1, 16'h8000, 1'b1);
    push_item(16'd2, 16'hC000, 1'b0);
    drain();
    write_reg(ADDR_NOISE_SIGMA, 32'd1);
    push_item(16'hFFFF, 16'h8000, 1'b0);
    push_item(16'hFFF0, 16'h4001, 1'b1);
    push_item(16'd1, 16'h8000, 1'b0);
    drain();

    sigmas = '{16'd0, 16'hFFFF, gnbm_pkg::SIGMA_RESET, 16'd1, 16'd0};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) sigmas[ph] = 16'($urandom);
      write_reg(ADDR_NOISE_SIGMA, {16'($urandom), sigmas[ph]});
      send_idle_off = (ph == 2);
      recv_idle_off = (ph == 2);
      push_random(150);
      if (ph == 1) recv_holdoff = 400;
      if (ph == 3) begin
        while (pending_q.size() > 75) @(posedge clk);
        send_pause = 1'b1;
        while (sample_q.size() != 0 || uniform.valid) @(posedge clk);
        send_pause = 1'b0;
        push_random(1);
      end
      drain();
    end

    if (timed_out) begin
      $display("*** FAILED ***");
    end else begin
      $display("Covered %0d samples over several sigma values incl. 0 and 0xFFFF,",
               samples_seen);
      $display("with random stalls, a long output hold-off and a full drain pause.");
      if (errors == 0 && sample_q.size() == 0) begin
        $display("*** PASSED ***");
      end else begin
        $display("*** FAILED ***");
      end
    end
    $finish;
  end

endmodule
